>>> rtl/wbo_pkg.sv
// Package for the wavetable bilinear oscillator.
// Holds field widths, default table geometry and the item opcodes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wbo_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PHASE_W = 16;
  localparam int MIX_W = 16;
  localparam int TSEL_W = 2;
  localparam int EIDX_W = 10;
  localparam int TABLE_COUNT_BITS_DEF = 2;
  localparam int TABLE_LENGTH_BITS_DEF = 10;
  localparam int BANKS = 4;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_WRITE  = 1'b1
  } opcode_t;

endpackage : wbo_pkg

`default_nettype wire

>>> rtl/wbo_if.sv
// Valid/ready channel interfaces for the wavetable bilinear oscillator.
// The input channel carries sample and table write words; the output channel carries samples.
// Depends on wbo_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface wbo_in_if
  import wbo_pkg::*;
;
  logic                valid;
  logic                ready;
  opcode_t             opcode;
  logic [PHASE_W-1:0]  phase;
  logic [MIX_W-1:0]    mix;
  logic [TSEL_W-1:0]   table_select;
  logic [EIDX_W-1:0]   entry_index;
  logic [SAMPLE_W-1:0] entry_value;

  modport source (
    output valid, opcode, phase, mix, table_select, entry_index, entry_value,
    input  ready
  );
  modport sink (
    input  valid, opcode, phase, mix, table_select, entry_index, entry_value,
    output ready
  );
endinterface : wbo_in_if

interface wbo_out_if
  import wbo_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (
    output valid, sample,
    input  ready
  );
  modport sink (
    input  valid, sample,
    output ready
  );
endinterface : wbo_out_if

`default_nettype wire

>>> rtl/wavetable_bilinear_oscillator.sv
// Wavetable oscillator with bilinear interpolation between entries and tables.
// Depends on wbo_pkg and the channel interfaces in wbo_if.sv.
//
// Usage: words arrive on in_if. A write word (opcode OP_WRITE) stores entry_value
// at entry entry_index of table table_select and gives no output. A sample word
// (opcode OP_SAMPLE) interpolates along phase within two neighboring tables, then
// between them by the low mix bits, and gives one word on out_if.
// The tables are held in four single-port-read banks, split by table parity and
// entry parity, so the four neighbors of a sample are all read at once.
// Throughput: one word per cycle while the output is not stalled; the pipeline is
// memory read, two phase multipliers, phase sum, mix multiplier and the output register.
// A table write is visible to a sample word accepted in the next cycle.
// When the receiver stalls with a sample waiting, the whole pipeline holds and
// in_if.ready drops; it rises again in the cycle the waiting sample is taken.
// Reset clears the pipeline valid flags only; table contents are undefined
// until written and must be loaded before samples read them.
`timescale 1ns / 1ps
`default_nettype none

module wavetable_bilinear_oscillator
  import wbo_pkg::*;
#(
  parameter int TABLE_COUNT_BITS  = TABLE_COUNT_BITS_DEF,
  parameter int TABLE_LENGTH_BITS = TABLE_LENGTH_BITS_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  wbo_in_if.sink       in_if,
  wbo_out_if.source    out_if
);

  localparam int TCB = TABLE_COUNT_BITS;
  localparam int TLB = TABLE_LENGTH_BITS;
  localparam int PFB = PHASE_W - TLB;
  localparam int MFB = MIX_W - TCB;
  localparam int AW = TCB + TLB - 2;
  localparam int BANK_DEPTH = 1 << AW;
  localparam int PPW = SAMPLE_W + PFB + 2;
  localparam int MPW = SAMPLE_W + MFB + 2;

  logic adv_c;
  logic acc_c;

  logic [TCB-1:0] ta_c;
  logic [TCB-1:0] tb_c;
  logic [TLB-1:0] e1_c;
  logic [TLB-1:0] e2_c;
  logic [TCB-1:0] wt_c;
  logic [TLB-1:0] we_c;
  logic [1:0]     wr_bank_c;
  logic [AW-1:0]  wr_addr_c;
  logic [AW-1:0]  rd_addr_c [BANKS];

  logic [SAMPLE_W-1:0] bank_q_r [BANKS];

  logic            v1_r;
  logic [PFB-1:0]  pf1_r;
  logic [MFB-1:0]  mf1_r;
  logic            ta0_1_r;
  logic            e0_1_r;

  logic [SAMPLE_W-1:0] a1_c, a2_c, b1_c, b2_c;
  logic signed [SAMPLE_W:0] da_c, db_c;
  logic signed [PPW-1:0]    pa_c, pb_c;

  logic                  v2_r;
  logic signed [PPW-1:0] pa2_r, pb2_r;
  logic [SAMPLE_W-1:0]   a2_base_r, b2_base_r;
  logic [MFB-1:0]        mf2_r;

  logic signed [PPW-1:0] suma_c, sumb_c;

  logic                v3_r;
  logic [SAMPLE_W-1:0] sa3_r, sb3_r;
  logic [MFB-1:0]      mf3_r;

  logic signed [SAMPLE_W:0] dm_c;
  logic signed [MPW-1:0]    pm_c;

  logic                  v4_r;
  logic signed [MPW-1:0] pm4_r;
  logic [SAMPLE_W-1:0]   sa4_r;

  logic signed [MPW-1:0] summ_c;

  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_sample_r;

  assign adv_c = !(out_valid_r && !out_if.ready);
  assign in_if.ready = adv_c;
  assign acc_c = in_if.valid && adv_c;

  assign ta_c = in_if.mix[MIX_W-1 -: TCB];
  assign tb_c = ta_c + 1'b1;
  assign e1_c = in_if.phase[PHASE_W-1 -: TLB];
  assign e2_c = e1_c + 1'b1;
  assign wt_c = TCB'(in_if.table_select);
  assign we_c = TLB'(in_if.entry_index);

  assign wr_bank_c = {wt_c[0], we_c[0]};
  assign wr_addr_c = (AW'(wt_c >> 1) << (TLB - 1)) | AW'(we_c >> 1);

  for (genvar g = 0; g < BANKS; g++) begin : g_bank
    localparam logic [1:0] BANK_ID = 2'(g);
    logic [SAMPLE_W-1:0] mem [BANK_DEPTH];
    logic [TCB-1:0]      rt_c;
    logic [TLB-1:0]      re_c;

    assign rt_c = (ta_c[0] == BANK_ID[1]) ? ta_c : tb_c;
    assign re_c = (e1_c[0] == BANK_ID[0]) ? e1_c : e2_c;
    assign rd_addr_c[g] = (AW'(rt_c >> 1) << (TLB - 1)) | AW'(re_c >> 1);

    always_ff @(posedge clk) begin
      if (acc_c && in_if.opcode == OP_WRITE && wr_bank_c == BANK_ID) begin
        mem[wr_addr_c] <= in_if.entry_value;
      end
      if (adv_c) begin
        bank_q_r[g] <= mem[rd_addr_c[g]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv_c) begin
      v1_r <= acc_c && in_if.opcode == OP_SAMPLE;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  always_comb begin
    a1_c = bank_q_r[{ta0_1_r, e0_1_r}];
    a2_c = bank_q_r[{ta0_1_r, !e0_1_r}];
    b1_c = bank_q_r[{!ta0_1_r, e0_1_r}];
    b2_c = bank_q_r[{!ta0_1_r, !e0_1_r}];
    da_c = $signed({1'b0, a2_c}) - $signed({1'b0, a1_c});
    db_c = $signed({1'b0, b2_c}) - $signed({1'b0, b1_c});
    pa_c = da_c * $signed({1'b0, pf1_r});
    pb_c = db_c * $signed({1'b0, pf1_r});
  end

  always_comb begin
    suma_c = $signed({2'b00, a2_base_r, PFB'(0)}) + pa2_r;
    sumb_c = $signed({2'b00, b2_base_r, PFB'(0)}) + pb2_r;
    dm_c = $signed({1'b0, sb3_r}) - $signed({1'b0, sa3_r});
    pm_c = dm_c * $signed({1'b0, mf3_r});
    summ_c = $signed({2'b00, sa4_r, MFB'(0)}) + pm4_r;
  end

  always_ff @(posedge clk) begin
    if (adv_c) begin
      pf1_r <= in_if.phase[PFB-1:0];
      mf1_r <= in_if.mix[MFB-1:0];
      ta0_1_r <= ta_c[0];
      e0_1_r <= e1_c[0];

      pa2_r <= pa_c;
      pb2_r <= pb_c;
      a2_base_r <= a1_c;
      b2_base_r <= b1_c;
      mf2_r <= mf1_r;

      sa3_r <= suma_c[PFB +: SAMPLE_W];
      sb3_r <= sumb_c[PFB +: SAMPLE_W];
      mf3_r <= mf2_r;

      pm4_r <= pm_c;
      sa4_r <= sa3_r;

      out_sample_r <= summ_c[MFB +: SAMPLE_W];
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.sample = out_sample_r;

  a_write_no_result : assert property (@(posedge clk) disable iff (!rst_n)
    acc_c && in_if.opcode == OP_WRITE |=> !v1_r)
    else $error("write word entered the sample pipeline");

  a_sample_enters : assert property (@(posedge clk) disable iff (!rst_n)
    acc_c && in_if.opcode == OP_SAMPLE |=> v1_r)
    else $error("accepted sample word was lost at the memory stage");

  a_last_stage_to_out : assert property (@(posedge clk) disable iff (!rst_n)
    adv_c && v4_r |=> out_valid_r)
    else $error("sample lost between last stage and output register");

  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    !adv_c |=> out_valid_r && $stable(out_sample_r) && $stable(v4_r))
    else $error("pipeline moved while the output was stalled");

endmodule : wavetable_bilinear_oscillator

`default_nettype wire

>>> dv/wavetable_bilinear_oscillator_tb.sv
// Self-checking testbench for the wavetable bilinear oscillator.
// Loads table entries, drives sample words and checks each output word against a local predictor.
// Depends on wbo_pkg, the channel interfaces in wbo_if.sv and the oscillator RTL.
`timescale 1ns / 1ps

module wavetable_bilinear_oscillator_tb;
  import wbo_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 7;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 20;
  localparam int PH_FRAC = PHASE_W - EIDX_W;
  localparam int MIX_FRAC = MIX_W - TSEL_W;
  localparam int MEM_DEPTH = 1 << (TSEL_W + EIDX_W);
  localparam int DIR_COUNT = 24;

  typedef struct packed {
    opcode_t             op;
    logic [PHASE_W-1:0]  phase;
    logic [MIX_W-1:0]    mix;
    logic [TSEL_W-1:0]   tsel;
    logic [EIDX_W-1:0]   eidx;
    logic [SAMPLE_W-1:0] eval;
  } osc_word_t;

  typedef struct packed {
    osc_word_t           w;
    logic                known;
    logic [SAMPLE_W-1:0] known_sample;
  } dir_row_t;

  // Rows with known set carry a sample that can be read straight off the loaded entries.
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{'{OP_WRITE,  16'h0000, 16'h0000, 2'd0, 10'd0,    16'h0000}, 1'b0, 16'h0000},
    '{'{OP_WRITE,  16'h0000, 16'h0000, 2'd0, 10'd1,    16'hFFFF}, 1'b0, 16'h0000},
    '{'{OP_WRITE,  16'h0000, 16'h0000, 2'd0, 10'd1023, 16'h8000}, 1'b0, 16'h0000},
    '{'{OP_WRITE,  16'h0000, 16'h0000, 2'd1, 10'd0,    16'hFFFF}, 1'b0, 16'h0000},
    '{'{OP_WRITE,  16'h0000, 16'h0000, 2'd1, 10'd1,    16'h0000}, 1'b0, 16'h0000},
    '{'{OP_WRITE,  16'h0000, 16'h0000, 2'd1, 10'd1023, 16'h0001}, 1'b0, 16'h0000},
    '{'{OP_WRITE,  16'h0000, 16'h0000, 2'd2, 10'd0,    16'h1234}, 1'b0, 16'h0000},
    '{'{OP_WRITE,  16'h0000, 16'h0000, 2'd2, 10'd1,    16'h5678}, 1'b0, 16'h0000},
    '{'{OP_WRITE,  16'h0000, 16'h0000, 2'd2, 10'd1023, 16'hFFFF}, 1'b0, 16'h0000},
    '{'{OP_WRITE,  16'h0000, 16'h0000, 2'd3, 10'd0,    16'hFFFF}, 1'b0, 16'h0000},
    '{'{OP_WRITE,  16'h0000, 16'h0000, 2'd3, 10'd1,    16'hFFFF}, 1'b0, 16'h0000},
    '{'{OP_WRITE,  16'h0000, 16'h0000, 2'd3, 10'd1023, 16'h0000}, 1'b0, 16'h0000},
    '{'{OP_SAMPLE, 16'h0000, 16'h0000, 2'd0, 10'd0,    16'h0000}, 1'b1, 16'h0000},
    '{'{OP_SAMPLE, 16'h0000, 16'h4000, 2'd0, 10'd0,    16'h0000}, 1'b1, 16'hFFFF},
    '{'{OP_SAMPLE, 16'h0000, 16'h8000, 2'd0, 10'd0,    16'h0000}, 1'b1, 16'h1234},
    '{'{OP_SAMPLE, 16'hFFC0, 16'hC000, 2'd0, 10'd0,    16'h0000}, 1'b1, 16'h0000},
    '{'{OP_SAMPLE, 16'hFFC0, 16'h0000, 2'd0, 10'd0,    16'h0000}, 1'b1, 16'h8000},
    '{'{OP_SAMPLE, 16'h003F, 16'h0000, 2'd0, 10'd0,    16'h0000}, 1'b0, 16'h0000},
    '{'{OP_SAMPLE, 16'hFFFF, 16'hFFFF, 2'd0, 10'd0,    16'h0000}, 1'b0, 16'h0000},
    '{'{OP_SAMPLE, 16'h0020, 16'h2000, 2'd0, 10'd0,    16'h0000}, 1'b0, 16'h0000},
    '{'{OP_SAMPLE, 16'h0001, 16'h7FFF, 2'd0, 10'd0,    16'h0000}, 1'b0, 16'h0000},
    '{'{OP_SAMPLE, 16'h0000, 16'h0000, 2'd3, 10'd1023, 16'hFFFF}, 1'b1, 16'h0000},
    '{'{OP_WRITE,  16'hFFFF, 16'hFFFF, 2'd1, 10'd0,    16'h7777}, 1'b0, 16'h0000},
    '{'{OP_SAMPLE, 16'h0000, 16'h4000, 2'd0, 10'd0,    16'h0000}, 1'b1, 16'h7777}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wbo_in_if  in_ch ();
  wbo_out_if out_ch ();

  wavetable_bilinear_oscillator i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  logic [SAMPLE_W-1:0] wave_mem [MEM_DEPTH];
  bit                  loaded [MEM_DEPTH];
  logic [SAMPLE_W-1:0] pending_samples [$];
  logic [TSEL_W+EIDX_W-1:0] sampled_spots [$];
  int                  mismatch_count = 0;
  int                  words_sent = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  stall_cycles = 0;
  bit                  hold_req = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [SAMPLE_W-1:0] lerp_frac(input logic [SAMPLE_W-1:0] a,
                                                     input logic [SAMPLE_W-1:0] b,
                                                     input logic [31:0] f, input int k);
    logic [31:0] acc;
    acc = ((32'd1 << k) - f) * a + f * b;
    acc = acc >> k;
    return acc[SAMPLE_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] bilinear_sample(input logic [PHASE_W-1:0] ph,
                                                          input logic [MIX_W-1:0] mx);
    logic [TSEL_W-1:0]   ta;
    logic [TSEL_W-1:0]   tb;
    logic [EIDX_W-1:0]   e1;
    logic [EIDX_W-1:0]   e2;
    logic [31:0]         pf;
    logic [31:0]         mf;
    logic [SAMPLE_W-1:0] sa;
    logic [SAMPLE_W-1:0] sb;
    ta = mx[MIX_W-1 -: TSEL_W];
    tb = ta + 1'b1;
    e1 = ph[PHASE_W-1 -: EIDX_W];
    e2 = e1 + 1'b1;
    pf = 32'(ph[PH_FRAC-1:0]);
    mf = 32'(mx[MIX_FRAC-1:0]);
    sa = lerp_frac(wave_mem[{ta, e1}], wave_mem[{ta, e2}], pf, PH_FRAC);
    sb = lerp_frac(wave_mem[{tb, e1}], wave_mem[{tb, e2}], pf, PH_FRAC);
    return lerp_frac(sa, sb, mf, MIX_FRAC);
  endfunction

  function automatic logic [15:0] pick_frac(input int nbits);
    logic [15:0] mask;
    mask = 16'((32'd1 << nbits) - 1);
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return mask;
      default: return 16'($urandom) & mask;
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic note_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_word(input osc_word_t w, input logic known,
                           input logic [SAMPLE_W-1:0] known_sample);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= w.op;
    in_ch.phase        <= w.phase;
    in_ch.mix          <= w.mix;
    in_ch.table_select <= w.tsel;
    in_ch.entry_index  <= w.eidx;
    in_ch.entry_value  <= w.eval;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    if (w.op == OP_WRITE) begin
      wave_mem[{w.tsel, w.eidx}] = w.eval;
      loaded[{w.tsel, w.eidx}] = 1'b1;
    end else begin
      pending_samples.push_back(known ? known_sample : bilinear_sample(w.phase, w.mix));
    end
  endtask

  task automatic write_entry(input logic [TSEL_W+EIDX_W-1:0] addr);
    osc_word_t w;
    w.op = OP_WRITE;
    w.phase = PHASE_W'($urandom);
    w.mix = MIX_W'($urandom);
    w.tsel = addr[TSEL_W+EIDX_W-1 -: TSEL_W];
    w.eidx = addr[EIDX_W-1:0];
    w.eval = pick_value();
    send_word(w, 1'b0, '0);
  endtask

  // Loads whatever the four neighbors still lack, then asks for the sample.
  task automatic sample_loaded_spot();
    logic [TSEL_W-1:0] ta;
    logic [EIDX_W-1:0] e1;
    logic [TSEL_W+EIDX_W-1:0] need [4];
    osc_word_t w;
    int i;
    if (sampled_spots.size() > 0 && $urandom_range(0, 1) == 1) begin
      {ta, e1} = sampled_spots[$urandom_range(0, sampled_spots.size() - 1)];
    end else begin
      ta = TSEL_W'($urandom);
      e1 = EIDX_W'($urandom);
      sampled_spots.push_back({ta, e1});
    end
    need[0] = {ta, e1};
    need[1] = {ta, e1 + 1'b1};
    need[2] = {ta + 1'b1, e1};
    need[3] = {ta + 1'b1, e1 + 1'b1};
    for (i = 0; i < 4; i++) begin
      if (!loaded[need[i]]) begin
        write_entry(need[i]);
      end
    end
    w.op = OP_SAMPLE;
    w.phase = {e1, PH_FRAC'(pick_frac(PH_FRAC))};
    w.mix = {ta, MIX_FRAC'(pick_frac(MIX_FRAC))};
    w.tsel = TSEL_W'($urandom);
    w.eidx = EIDX_W'($urandom);
    w.eval = SAMPLE_W'($urandom);
    send_word(w, 1'b0, '0);
  endtask

  task automatic run_random(input int target);
    while (words_sent < target) begin
      if ($urandom_range(0, 3) == 0) begin
        write_entry((TSEL_W + EIDX_W)'($urandom));
      end else begin
        sample_loaded_spot();
      end
    end
  endtask

  always begin
    @(negedge clk);
    if (hold_req) begin
      hold_req = 1'b0;
      repeat (HOLD_CYCLES) begin
        out_ch.ready <= 1'b0;
        @(negedge clk);
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_samples.size() == 0) begin
        note_mismatch($sformatf("sample %h with none expected", out_ch.sample));
      end else if (out_ch.sample !== pending_samples[0]) begin
        note_mismatch($sformatf("sample %h, expected %h", out_ch.sample, pending_samples[0]));
        void'(pending_samples.pop_front());
      end else begin
        void'(pending_samples.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.opcode       = OP_SAMPLE;
    in_ch.phase        = '0;
    in_ch.mix          = '0;
    in_ch.table_select = '0;
    in_ch.entry_index  = '0;
    in_ch.entry_value  = '0;
    out_ch.ready       = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_COUNT; r++) begin
      send_word(DIR_ROWS[r].w, DIR_ROWS[r].known, DIR_ROWS[r].known_sample);
    end

    send_idle_pct = 15;
    recv_idle_pct = 78;
    hold_req = 1'b1;
    run_random(675);

    send_idle_pct = 78;
    recv_idle_pct = 15;
    run_random(1300);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    run_random(1950);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_samples.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule : wavetable_bilinear_oscillator_tb

>>> files.f
rtl/wbo_pkg.sv
rtl/wbo_if.sv
rtl/wavetable_bilinear_oscillator.sv
dv/wavetable_bilinear_oscillator_tb.sv
